### rtl/dfr_pkg.sv
// dfr_pkg: types and constants shared by the decimating FIR blocks.
// Register indexes, field widths, controller/datapath command and status.
// No dependencies.
package dfr_pkg;

  // Field and arithmetic widths
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 36;   // 16 products of 31 bits plus sign
  localparam int FRAC_W     = 14;   // Q2.14 coefficients
  localparam int POS_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_CFG_W  = 13;
  localparam int TAPS_CFG_W = 5;
  localparam int COEF_WORDS = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_3     = 3'd5;

  // Register reset values and limits
  localparam logic [LEN_CFG_W-1:0]  LINE_LENGTH_RST = 13'd64;
  localparam logic [LEN_CFG_W-1:0]  LINE_LENGTH_MIN = 13'd8;
  localparam logic [TAPS_CFG_W-1:0] TAP_COUNT_RST   = 5'd16;

  // Commands from controller to datapath
  typedef struct packed {
    logic             wr;     // store the incoming sample
    logic             latch;  // latch line length and tap count
    logic             clr;    // clear accumulator
    logic             issue;  // start one tap through the MAC pipe
    logic             load;   // load result into output register
    logic             last;   // result is the last of the line
    logic [POS_W-1:0] pos;    // output index within the line
  } dfr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic busy;      // MAC pipe holds taps in flight
    logic out_free;  // output register can take a result this cycle
  } dfr_sts_t;

endpackage

### rtl/dfr_datapath.sv
// dfr_datapath: config registers, line store, mirrored address, MAC pipe,
// rounding/saturation and output register.
// Depends on dfr_pkg.
module dfr_datapath import dfr_pkg::*; #(
  parameter int LINE_MAX = 4096,
  parameter int MAX_TAPS = 16,
  localparam int LW = $clog2(LINE_MAX + 1),
  localparam int AW = $clog2(LINE_MAX),
  localparam int TW = $clog2(MAX_TAPS + 1),
  localparam int SW = LW + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // config write port
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  // sample in
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  // controller interface
  input  dfr_cmd_t                    cmd,
  input  logic [TW-1:0]               tap_idx,
  input  logic signed [SW-1:0]        rd_pos,
  input  logic [AW-1:0]               wr_addr,
  output dfr_sts_t                    sts,
  output logic [LW-1:0]               lat_len,
  output logic [TW-1:0]               lat_taps,
  // result out
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  out_filtered,
  output logic [POS_W-1:0]            out_position,
  output logic                        out_clipped,
  output logic                        out_line_done
);

  localparam logic signed [SW-1:0]    ONE_S  = SW'(1);
  localparam logic signed [SW-1:0]    ZERO_S = '0;
  localparam logic signed [ACC_W:0]   RBIAS  = (ACC_W+1)'(8192);
  localparam logic signed [ACC_W:0]   SAT_HI = (ACC_W+1)'(32767);
  localparam logic signed [ACC_W:0]   SAT_LO = -(ACC_W+1)'(32768);

  // Config registers
  logic [LEN_CFG_W-1:0]  len_cfg_r;
  logic [TAPS_CFG_W-1:0] taps_cfg_r;
  logic [CFG_DATA_W-1:0] coeff_r [COEF_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r  <= LINE_LENGTH_RST;
      taps_cfg_r <= TAP_COUNT_RST;
      for (int w = 0; w < COEF_WORDS; w++) coeff_r[w] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LINE_LENGTH: len_cfg_r  <= cfg_data[LEN_CFG_W-1:0];
        REG_TAP_COUNT:   taps_cfg_r <= cfg_data[TAPS_CFG_W-1:0];
        REG_COEFF_0:     coeff_r[0] <= cfg_data;
        REG_COEFF_1:     coeff_r[1] <= cfg_data;
        REG_COEFF_2:     coeff_r[2] <= cfg_data;
        REG_COEFF_3:     coeff_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-line latch of clamped length and tap count
  logic [LW-1:0] lat_len_r, lat_len_nxt;
  logic [TW-1:0] lat_taps_r, lat_taps_nxt;

  always_comb begin
    if (len_cfg_r < LINE_LENGTH_MIN)        lat_len_nxt = LW'(LINE_LENGTH_MIN);
    else if (32'(len_cfg_r) > LINE_MAX)     lat_len_nxt = LW'(LINE_MAX);
    else                                    lat_len_nxt = LW'(len_cfg_r);
    if (taps_cfg_r == '0)                   lat_taps_nxt = TW'(1);
    else if (32'(taps_cfg_r) > MAX_TAPS)    lat_taps_nxt = TW'(MAX_TAPS);
    else                                    lat_taps_nxt = TW'(taps_cfg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_len_r  <= LW'(LINE_LENGTH_RST);
      lat_taps_r <= TW'(MAX_TAPS);
    end else if (cmd.latch) begin
      lat_len_r  <= lat_len_nxt;
      lat_taps_r <= lat_taps_nxt;
    end
  end

  assign lat_len  = lat_len_r;
  assign lat_taps = lat_taps_r;

  // Mirror the tap position into the line, edge sample repeated
  logic signed [SW-1:0] len_s, m1, m2, m3;
  logic [AW-1:0]        rd_addr;

  always_comb begin
    len_s = $signed(SW'(lat_len_r));
    m1 = (rd_pos < ZERO_S) ? ~rd_pos : rd_pos;
    m2 = (m1 >= len_s) ? (len_s + len_s - m1 - ONE_S) : m1;
    if (m2 < ZERO_S)                m3 = ZERO_S;
    else if (m2 > len_s - ONE_S)    m3 = len_s - ONE_S;
    else                            m3 = m2;
  end
  assign rd_addr = m3[AW-1:0];

  // Coefficient select
  logic [3:0]               tap4;
  logic [CFG_DATA_W-1:0]    coef_word;
  logic signed [COEF_W-1:0] coef_sel;

  assign tap4      = 4'(tap_idx);
  assign coef_word = coeff_r[tap4[3:2]];
  assign coef_sel  = $signed(coef_word[COEF_W*tap4[1:0] +: COEF_W]);

  // MAC pipe: address -> store read -> product -> accumulate
  logic                      a_v_r, b_v_r, c_v_r;
  logic [AW-1:0]             a_addr_r;
  logic signed [COEF_W-1:0]  a_coef_r, b_coef_r;
  logic signed [SAMPLE_W-1:0] b_smp_r;
  logic signed [PROD_W-1:0]  c_prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [SAMPLE_W-1:0]       store_mem [LINE_MAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= cmd.issue;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr) store_mem[wr_addr] <= in_sample;
    b_smp_r <= $signed(store_mem[a_addr_r]);
  end

  always_ff @(posedge clk) begin
    a_addr_r <= rd_addr;
    a_coef_r <= coef_sel;
    b_coef_r <= a_coef_r;
    c_prod_r <= b_smp_r * b_coef_r;
    if (cmd.clr)      acc_r <= '0;
    else if (c_v_r)   acc_r <= acc_r + ACC_W'(c_prod_r);
  end

  assign sts.busy = a_v_r | b_v_r | c_v_r;

  // Round half up, shift out fraction, saturate
  logic signed [ACC_W:0]    rsum, rshift;
  logic signed [SAMPLE_W-1:0] sat_val;
  logic                     sat_clip;

  always_comb begin
    rsum   = (ACC_W+1)'(acc_r) + RBIAS;
    rshift = rsum >>> FRAC_W;
    if (rshift > SAT_HI) begin
      sat_val  = SAMPLE_W'(SAT_HI);
      sat_clip = 1'b1;
    end else if (rshift < SAT_LO) begin
      sat_val  = SAMPLE_W'(SAT_LO);
      sat_clip = 1'b1;
    end else begin
      sat_val  = rshift[SAMPLE_W-1:0];
      sat_clip = 1'b0;
    end
  end

  // Output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_filtered_r;
  logic [POS_W-1:0]           out_position_r;
  logic                       out_clipped_r, out_line_done_r;

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_filtered_r  <= sat_val;
      out_position_r  <= cmd.pos;
      out_clipped_r   <= sat_clip;
      out_line_done_r <= cmd.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_filtered  = out_filtered_r;
  assign out_position  = out_position_r;
  assign out_clipped   = out_clipped_r;
  assign out_line_done = out_line_done_r;

endmodule

### rtl/dfr_ctrl.sv
// dfr_ctrl: sequencer for the decimating FIR. Counts samples and outputs,
// decides when an output is ready and steps the MAC through the taps.
// Depends on dfr_pkg.
module dfr_ctrl import dfr_pkg::*; #(
  parameter int LINE_MAX = 4096,
  parameter int MAX_TAPS = 16,
  localparam int LW = $clog2(LINE_MAX + 1),
  localparam int AW = $clog2(LINE_MAX),
  localparam int TW = $clog2(MAX_TAPS + 1),
  localparam int SW = LW + 2,
  localparam int OW = $clog2((LINE_MAX + 1) / 2 + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dfr_sts_t             sts,
  input  logic [LW-1:0]        lat_len,
  input  logic [TW-1:0]        lat_taps,
  output dfr_cmd_t             cmd,
  output logic [TW-1:0]        tap_idx,
  output logic signed [SW-1:0] rd_pos,
  output logic [AW-1:0]        wr_addr
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] seen_r, seen_nxt;
  logic [OW-1:0] nout_r, nout_nxt;
  logic [TW-1:0] k_r, k_nxt;

  // Line geometry for the current output
  logic [TW-1:0]        half;
  logic [OW-1:0]        count;
  logic signed [SW-1:0] base, need, seen_s;
  logic                 at_end, more;

  always_comb begin
    half   = lat_taps >> 1;
    count  = OW'(((LW+1)'(lat_len) + (LW+1)'(1)) >> 1);
    base   = $signed(SW'({nout_r, 1'b0})) - $signed(SW'(half));
    need   = base + $signed(SW'(lat_taps)) - ONE_S;
    seen_s = $signed(SW'(seen_r));
    at_end = (seen_r >= lat_len);
    more   = (nout_r < count) && (at_end || (need < seen_s));
  end

  assign rd_pos  = base + $signed(SW'(k_r));
  assign tap_idx = k_r;
  assign wr_addr = seen_r[AW-1:0];

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    nout_nxt  = nout_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.pos   = POS_W'(nout_r);
    cmd.last  = ((OW+1)'(nout_r) + (OW+1)'(1)) == (OW+1)'(count);
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr    = 1'b1;
          cmd.latch = (seen_r == '0);
          seen_nxt  = seen_r + LW'(1);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (more) begin
          cmd.clr   = 1'b1;
          k_nxt     = '0;
          state_nxt = S_MAC;
        end else begin
          if (at_end) begin
            seen_nxt = '0;
            nout_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_MAC: begin
        cmd.issue = 1'b1;
        k_nxt     = k_r + TW'(1);
        if (k_r == lat_taps - TW'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.busy) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          nout_nxt  = nout_r + OW'(1);
          state_nxt = S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r  <= '0;
      nout_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      nout_r  <= nout_nxt;
      k_r     <= k_nxt;
    end
  end

endmodule

### rtl/decimating_fir_reflect.sv
// decimating_fir_reflect: top level of the decimate-by-two FIR with mirrored
// line edges. Joins the sequencer (dfr_ctrl) and the datapath (dfr_datapath).
// Depends on dfr_pkg, dfr_ctrl, dfr_datapath.
//
// Usage:
//  - Input channel (in_valid/in_stall/in_sample) takes one sample per request,
//    line_length samples per line. Output channel (out_valid/out_stall) gives
//    filtered, position, clip flag and a line-done flag on the last output.
//  - Config port: write line_length, tap_count and four coefficient words
//    while the block is idle. Length and taps are latched on a line's first
//    sample; coefficients are used as they stand.
//  - An output leaves once its last needed sample is in; the trailing outputs
//    of a line follow its final sample. (line_length+1)/2 outputs per line.
//  - Timing: a sample that completes no output only passes the idle and check
//    states; each output it completes adds a pass in which one shared
//    multiply-accumulate walks the taps, then the store read, product and
//    accumulate stages drain, the output is loaded once the register is free
//    and the check runs again.
//  - The output register lets the block take the next sample while a result
//    waits; with the receiver stalled, it holds at the next finished result.
//  - Reset clears counters, the output valid and the registers to defaults.
//    The line store is not cleared; only written entries are ever read.
module decimating_fir_reflect import dfr_pkg::*; #(
  parameter int LINE_MAX = 4096,
  parameter int MAX_TAPS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // config port
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  out_filtered,
  output logic [POS_W-1:0]            out_position,
  output logic                        out_clipped,
  output logic                        out_line_done
);

  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int AW = $clog2(LINE_MAX);
  localparam int TW = $clog2(MAX_TAPS + 1);
  localparam int SW = LW + 2;

  dfr_cmd_t             cmd;
  dfr_sts_t             sts;
  logic [LW-1:0]        lat_len;
  logic [TW-1:0]        lat_taps;
  logic [TW-1:0]        tap_idx;
  logic signed [SW-1:0] rd_pos;
  logic [AW-1:0]        wr_addr;

  dfr_ctrl #(
    .LINE_MAX (LINE_MAX),
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .lat_len  (lat_len),
    .lat_taps (lat_taps),
    .cmd      (cmd),
    .tap_idx  (tap_idx),
    .rd_pos   (rd_pos),
    .wr_addr  (wr_addr)
  );

  dfr_datapath #(
    .LINE_MAX (LINE_MAX),
    .MAX_TAPS (MAX_TAPS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_sample     (in_sample),
    .cmd           (cmd),
    .tap_idx       (tap_idx),
    .rd_pos        (rd_pos),
    .wr_addr       (wr_addr),
    .sts           (sts),
    .lat_len       (lat_len),
    .lat_taps      (lat_taps),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_filtered  (out_filtered),
    .out_position  (out_position),
    .out_clipped   (out_clipped),
    .out_line_done (out_line_done)
  );

endmodule

### rtl/dfr_chk.sv
// dfr_chk: port-level checks for decimating_fir_reflect, and its bind.
// Depends on dfr_pkg.
module dfr_chk import dfr_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SAMPLE_W-1:0] out_filtered,
  input logic [POS_W-1:0]    out_position,
  input logic                out_clipped,
  input logic                out_line_done
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered) &&
      $stable(out_position) && $stable(out_clipped) && $stable(out_line_done))
    else $error("stalled result changed");

  // Reset empties the output register
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A clipped result sits at one of the saturation limits
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_filtered == 16'h7FFF || out_filtered == 16'h8000)
    else $error("clip flag without saturated value");

  // After taking a request the block stalls the input in the cycle after
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken on consecutive cycles");

endmodule

bind decimating_fir_reflect dfr_chk u_dfr_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_filtered  (out_filtered),
  .out_position  (out_position),
  .out_clipped   (out_clipped),
  .out_line_done (out_line_done)
);

### tb/dfr_out_checker.sv
`timescale 1ns / 100ps
// dfr_out_checker: watches the config port and both channels of the decimating FIR,
// predicts each filtered output and compares the outputs in order.
// Depends on dfr_pkg.
module dfr_out_checker import dfr_pkg::*; #(
  parameter int LINE_MAX = 4096,
  parameter int MAX_TAPS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] out_filtered,
  input  logic [POS_W-1:0]           out_position,
  input  logic                       out_clipped,
  input  logic                       out_line_done,
  output int                         fail_count,
  output int                         pending,
  output int                         results_checked
);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic [POS_W-1:0]           position;
    logic                       clipped;
    logic                       line_done;
  } fir_out_t;

  // Outputs predicted but not yet seen on the result channel
  fir_out_t pending_outputs[$];

  // Register copies as written on the config port
  logic [LEN_CFG_W-1:0]  len_reg;
  logic [TAPS_CFG_W-1:0] taps_reg;
  logic [CFG_DATA_W-1:0] coef_reg [COEF_WORDS];

  // Line state: stored samples, progress, length and taps latched per line
  logic [SAMPLE_W-1:0] line_mem [LINE_MAX];
  int seen, next_idx, line_len, line_taps;
  int errors, checked;

  function automatic int tap_coef(input int k);
    logic signed [COEF_W-1:0] c;
    c = coef_reg[k / 4][(k % 4) * COEF_W +: COEF_W];
    return c;
  endfunction

  // Mirror with the edge sample repeated, then clamp into the line
  function automatic int reflect(input int r, input int len);
    int m;
    m = r;
    if (m < 0) m = -m - 1;
    if (m >= len) m = 2 * len - m - 1;
    if (m < 0) m = 0;
    if (m > len - 1) m = len - 1;
    return m;
  endfunction

  // Store one sample and queue every output it completes
  task automatic filter_sample(input logic [SAMPLE_W-1:0] s);
    int half, count, need, k, produced;
    bit at_end, stop;
    longint acc, r;
    logic signed [SAMPLE_W-1:0] x;
    fir_out_t res;
    if (seen == 0) begin
      line_len = int'(len_reg);
      if (line_len < int'(LINE_LENGTH_MIN)) line_len = int'(LINE_LENGTH_MIN);
      if (line_len > LINE_MAX) line_len = LINE_MAX;
      line_taps = int'(taps_reg);
      if (line_taps < 1) line_taps = 1;
      if (line_taps > MAX_TAPS) line_taps = MAX_TAPS;
      next_idx = 0;
    end
    if (seen < line_len) line_mem[seen] = s;
    seen++;
    half = line_taps / 2;
    count = (line_len + 1) / 2;
    at_end = (seen >= line_len);
    produced = 0;
    stop = 1'b0;
    while (!stop && next_idx < count && produced < 9) begin
      need = 2 * next_idx - half + line_taps - 1;
      if (need > line_len - 1) need = line_len - 1;
      if (!at_end && need >= seen) begin
        stop = 1'b1;
      end else begin
        acc = 0;
        for (k = 0; k < line_taps; k++) begin
          x = line_mem[reflect(2 * next_idx - half + k, line_len)];
          acc += longint'(tap_coef(k)) * longint'(x);
        end
        // round half up, then saturate
        r = (acc + 64'sd8192) >>> FRAC_W;
        res.clipped = 1'b0;
        if (r > 32767) begin
          r = 32767;
          res.clipped = 1'b1;
        end else if (r < -32768) begin
          r = -32768;
          res.clipped = 1'b1;
        end
        res.filtered  = r[SAMPLE_W-1:0];
        res.position  = next_idx[POS_W-1:0];
        res.line_done = (next_idx + 1 == count);
        pending_outputs.push_back(res);
        produced++;
        next_idx++;
      end
    end
    if (at_end) begin
      seen = 0;
      next_idx = 0;
    end
  endtask

  always @(posedge clk) begin
    fir_out_t got, want;
    if (!rst_n) begin
      len_reg  = LINE_LENGTH_RST;
      taps_reg = TAP_COUNT_RST;
      foreach (coef_reg[w]) coef_reg[w] = '0;
      seen = 0;
      next_idx = 0;
      line_len = int'(LINE_LENGTH_RST);
      line_taps = int'(TAP_COUNT_RST);
      pending_outputs.delete();
      errors = 0;
      checked = 0;
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LINE_LENGTH: len_reg     = cfg_data[LEN_CFG_W-1:0];
          REG_TAP_COUNT:   taps_reg    = cfg_data[TAPS_CFG_W-1:0];
          REG_COEFF_0:     coef_reg[0] = cfg_data;
          REG_COEFF_1:     coef_reg[1] = cfg_data;
          REG_COEFF_2:     coef_reg[2] = cfg_data;
          REG_COEFF_3:     coef_reg[3] = cfg_data;
          default: ;
        endcase
      end
      // accepted sample request
      if (in_valid && !in_stall) filter_sample(in_sample);
      // accepted output request
      if (out_valid && !out_stall) begin
        got.filtered  = out_filtered;
        got.position  = out_position;
        got.clipped   = out_clipped;
        got.line_done = out_line_done;
        if (pending_outputs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected output: filtered %0d pos %0d clipped %0b done %0b",
                     $time, got.filtered, got.position, got.clipped, got.line_done);
        end else begin
          want = pending_outputs.pop_front();
          checked++;
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: output mismatch: expected filtered %0d pos %0d clipped %0b done %0b, %s",
                       $time, want.filtered, want.position, want.clipped, want.line_done,
                       $sformatf("got filtered %0d pos %0d clipped %0b done %0b",
                                 got.filtered, got.position, got.clipped, got.line_done));
          end
        end
      end
    end
    pending <= pending_outputs.size();
    fail_count <= errors;
    results_checked <= checked;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for decimating_fir_reflect; drives config writes, sample
// lines and output stalls, and takes its verdict from dfr_out_checker.
// Depends on dfr_pkg, decimating_fir_reflect, dfr_out_checker.
module tb;
  import dfr_pkg::*;

  localparam int LINE_MAX      = 4096;
  localparam int MAX_TAPS      = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 290;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_filtered;
  logic [POS_W-1:0]           out_position;
  logic                       out_clipped;
  logic                       out_line_done;

  int fail_count, pending, results_checked;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int samples_sent = 0;
  int lines_sent = 0;
  int cur_len = 64;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  decimating_fir_reflect #(.LINE_MAX(LINE_MAX), .MAX_TAPS(MAX_TAPS)) dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_sample,
    .out_valid, .out_stall, .out_filtered, .out_position, .out_clipped, .out_line_done
  );

  dfr_out_checker #(.LINE_MAX(LINE_MAX), .MAX_TAPS(MAX_TAPS)) u_checker (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_sample,
    .out_valid, .out_stall, .out_filtered, .out_position, .out_clipped, .out_line_done,
    .fail_count, .pending, .results_checked
  );

  // Receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SENDER:   begin tx_idle_pct = 69; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
      default:       begin tx_idle_pct = 15; rx_stall_pct = 15; end
    endcase
  endtask

  // One sample request, with random idle cycles ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
  endtask

  // Drop valid, wait for every expected output, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Idle the block, then write all six registers
  task automatic load_setup(input logic [CFG_DATA_W-1:0] len_w, taps_w, c0, c1, c2, c3);
    settle();
    write_reg(REG_LINE_LENGTH, len_w);
    write_reg(REG_TAP_COUNT, taps_w);
    write_reg(REG_COEFF_0, c0);
    write_reg(REG_COEFF_1, c1);
    write_reg(REG_COEFF_2, c2);
    write_reg(REG_COEFF_3, c3);
    cfg_release();
    cur_len = int'(len_w[LEN_CFG_W-1:0]);
    if (cur_len < int'(LINE_LENGTH_MIN)) cur_len = int'(LINE_LENGTH_MIN);
    if (cur_len > LINE_MAX) cur_len = LINE_MAX;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Full random taps clip often; small ones (about +-0.25) keep sums in range
  function automatic logic [CFG_DATA_W-1:0] coef_word(input bit full);
    logic [CFG_DATA_W-1:0] w;
    int j;
    w = {$urandom, $urandom};
    if (!full)
      for (j = 0; j < 4; j++) w[j * COEF_W +: COEF_W] = COEF_W'($urandom_range(0, 8191)) - 16'd4096;
    return w;
  endfunction

  // Mostly short lines; now and then below the minimum or a bit longer
  function automatic logic [CFG_DATA_W-1:0] len_word();
    logic [CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       w[LEN_CFG_W-1:0] = LEN_CFG_W'($urandom_range(0, 7));
      1:       w[LEN_CFG_W-1:0] = LEN_CFG_W'($urandom_range(41, 130));
      default: w[LEN_CFG_W-1:0] = LEN_CFG_W'($urandom_range(8, 40));
    endcase
    return w;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] taps_word();
    logic [CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) w[TAPS_CFG_W-1:0] = TAPS_CFG_W'($urandom_range(0, 31));
    else w[TAPS_CFG_W-1:0] = TAPS_CFG_W'($urandom_range(1, 16));
    return w;
  endfunction

  task automatic run_line(input int n);
    int i;
    for (i = 0; i < n; i++) send_sample(random_sample());
    lines_sent++;
  endtask

  initial begin
    logic [SAMPLE_W-1:0] burst [9];
    int k, line_no, random_items;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Full-scale taps against full-scale samples: saturation both ways
    load_setup(64'd8, 64'd16, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    burst = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF,
              16'h0000};
    for (k = 0; k < 8; k++) send_sample(burst[k]);
    lines_sent++;

    // Length and taps below range clamp to 8 and 1; unit tap hits rounding ties
    load_setup(64'd0, 64'd0, 64'd1, 64'd0, 64'd0, 64'd0);
    burst = '{16'h2000, 16'h0000, 16'hE000, 16'h0000, 16'h6000, 16'h0000, 16'hA000, 16'h0000,
              16'h0000};
    for (k = 0; k < 8; k++) send_sample(burst[k]);
    lines_sent++;

    // Odd length, taps above range; a length write mid-line must not apply yet
    load_setup(64'd9, 64'd31, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    burst = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000,
              16'h8000};
    for (k = 0; k < 4; k++) send_sample(burst[k]);
    settle();
    write_reg(REG_LINE_LENGTH, 64'd12);
    cfg_release();
    for (k = 4; k < 9; k++) send_sample(burst[k]);
    lines_sent++;

    // Random lines; settings change between some lines, idle mode on every line
    random_items = 0;
    line_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (line_no == 3) begin
        // sender keeps offering while the receiver holds off
        load_setup(64'd48, 64'd16, coef_word(1'b0), coef_word(1'b0), coef_word(1'b0),
                   coef_word(1'b0));
        set_idle(IDLE_NONE);
        hold_go = 1'b1;
      end else begin
        if (line_no == 0 || $urandom_range(0, 2) != 0)
          load_setup(len_word(), taps_word(), coef_word($urandom_range(0, 3) == 0),
                     coef_word($urandom_range(0, 3) == 0), coef_word($urandom_range(0, 3) == 0),
                     coef_word($urandom_range(0, 3) == 0));
        set_idle(idle_mode_e'(line_no % 4));
      end
      run_line(cur_len);
      random_items += cur_len;
      line_no++;
    end

    // Length word with all upper bits set; only the low 13 bits count
    load_setup({{(CFG_DATA_W - LEN_CFG_W){1'b1}}, 13'd32}, 64'd16, coef_word(1'b0),
               coef_word(1'b0), coef_word(1'b0), coef_word(1'b0));
    set_idle(IDLE_BOTH);
    run_line(cur_len);

    settle();
    $display("Covered %0d samples in %0d lines, %0d outputs checked, %0d failures.",
             samples_sent, lines_sent, results_checked, fail_count);
    $display("Lengths 8 to 130 with short lengths clamped, 1 to 16 taps, edge mirroring, ties, saturation.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
